// ===== hw/rtl/orp_pkg.sv =====
// orp_pkg: shared types and constants of the object record parser.
// Used by orp_front, orp_back and object_record_parser; no dependencies.
package orp_pkg;

  // item queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // record type bytes
  localparam logic [7:0] TYPE_NAME_A = 8'h83;
  localparam logic [7:0] TYPE_NAME_B = 8'h84;
  localparam logic [7:0] TYPE_EXP_A  = 8'h14;
  localparam logic [7:0] TYPE_EXP_B  = 8'h94;

  // name offset selectors and the offsets they pick
  localparam logic [7:0] SEL_C0 = 8'hC0;
  localparam logic [7:0] SEL_B0 = 8'hB0;
  localparam logic [7:0] SEL_A0 = 8'hA0;
  localparam logic [7:0] SEL_20 = 8'h20;
  localparam logic [5:0] OFF_1C = 6'h1C;
  localparam logic [5:0] OFF_20 = 6'h20;
  localparam logic [5:0] OFF_24 = 6'h24;

  // export entry type bytes
  localparam logic [7:0] ETYPE_00 = 8'h00;
  localparam logic [7:0] ETYPE_20 = 8'h20;
  localparam logic [7:0] ETYPE_40 = 8'h40;

  localparam logic [7:0] CHR_LO   = 8'h20;
  localparam logic [7:0] CHR_HI   = 8'h7E;
  localparam logic [7:0] SUM_OK   = 8'hFF;
  localparam logic [7:0] LIMIT_RST = 8'd200;

  // input kinds
  localparam logic IK_BYTE = 1'b0;
  localparam logic IK_EOF  = 1'b1;

  // result kinds
  localparam logic [2:0] RK_NAME_START = 3'd0;
  localparam logic [2:0] RK_NAME_BYTE  = 3'd1;
  localparam logic [2:0] RK_SYM_START  = 3'd2;
  localparam logic [2:0] RK_SYM_BYTE   = 3'd3;
  localparam logic [2:0] RK_REC        = 3'd4;
  localparam logic [2:0] RK_FILE       = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CORRUPT = 2'd1;
  localparam logic [1:0] ST_EXPORTS = 2'd2;

  typedef enum logic [1:0] {
    PH_TYPE, PH_LEN, PH_PAYLOAD, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    EN_IDLE, EN_NAME_SEL, EN_NAME_LEN, EN_NAME_CHR,
    EN_EXP_TYPE, EN_EXP_LEN, EN_EXP_CHR
  } entry_t;

  // classified input item
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       name_type;
    logic       export_type;
    logic       sel_ok;
    logic [5:0] sel_off;
    logic       printable;
    logic       skip_ok;
    logic       skip8;
  } item_t;

  // one result item
  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] byte_value;
    logic [1:0] status;
    logic [7:0] export_count;
  } result_t;

endpackage

// ===== hw/rtl/orp_front.sv =====
// orp_front: accepts input bytes, decodes byte classes, and queues items.
// Depends on orp_pkg.
module orp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic [0:0]     in_tuser,
  output logic           q_valid,
  output orp_pkg::item_t q_item,
  input  logic           q_pop
);
  import orp_pkg::*;

  item_t          q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  item_t          cls;
  logic           push;

  always_comb begin
    cls           = '0;
    cls.kind      = in_tuser[0];
    cls.data      = in_tdata;
    cls.name_type   = (in_tdata == TYPE_NAME_A) || (in_tdata == TYPE_NAME_B);
    cls.export_type = (in_tdata == TYPE_EXP_A) || (in_tdata == TYPE_EXP_B);
    case (in_tdata)
      SEL_C0, SEL_B0: begin
        cls.sel_ok  = 1'b1;
        cls.sel_off = OFF_1C;
      end
      SEL_A0: begin
        cls.sel_ok  = 1'b1;
        cls.sel_off = OFF_20;
      end
      SEL_20: begin
        cls.sel_ok  = 1'b1;
        cls.sel_off = OFF_24;
      end
      default: begin
        cls.sel_ok  = 1'b0;
        cls.sel_off = '0;
      end
    endcase
    cls.printable = (in_tdata >= CHR_LO) && (in_tdata <= CHR_HI);
    cls.skip_ok   = (in_tdata == ETYPE_00) || (in_tdata == ETYPE_20) ||
                    (in_tdata == ETYPE_40);
    cls.skip8     = (in_tdata == ETYPE_40);
  end

  assign in_tready = (cnt_r != (QAW+1)'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

endmodule

// ===== hw/rtl/orp_back.sv =====
// orp_back: record and entry parser with result register.
// Depends on orp_pkg; fed by the orp_front queue.
module orp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_data,
  input  logic             q_valid,
  input  orp_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output orp_pkg::result_t out_res
);
  import orp_pkg::*;

  logic [7:0] limit_r;

  phase_t     phase_r, phase_nxt;
  entry_t     entry_r, entry_nxt;
  logic       is_name_r, is_name_nxt;
  logic       is_exp_r, is_exp_nxt;
  logic [7:0] size_r, size_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [8:0] fp_r, fp_nxt;
  logic [7:0] sr_r, sr_nxt;
  logic [1:0] rerr_r, rerr_nxt;
  logic [1:0] ferr_r, ferr_nxt;
  logic [7:0] exp_r, exp_nxt;

  logic       ov_r;
  result_t    res_r;

  logic       take;
  logic [7:0] b;
  logic [8:0] b9, pos9, posn9, size9;
  logic [7:0] sum_add, size_len;
  logic       fp_hit, str_over, limit_hit;

  // payload parse results
  logic [1:0] p_fail;
  logic       p_emit, p_inc;
  logic [2:0] p_kind;
  entry_t     p_entry;
  logic [8:0] p_fp;
  logic [7:0] p_sr;

  // length byte results
  logic       l_short, l_fail;
  entry_t     l_entry;

  // verdict
  logic       verdict;
  logic [1:0] rerr_cur, v_status;

  logic       ev_valid;
  result_t    ev;

  assign take      = q_valid && (!ov_r || out_ready);
  assign q_pop     = take;
  assign b         = q_item.data;
  assign b9        = {1'b0, b};
  assign pos9      = {1'b0, pos_r};
  assign posn9     = pos9 + 9'd1;
  assign size9     = {1'b0, size_r};
  assign sum_add   = sum_r + b;
  assign size_len  = b - 8'd2;
  assign fp_hit    = (pos9 == fp_r);
  assign str_over  = (pos9 + b9) >= size9;
  assign limit_hit = (exp_r == (limit_r - 8'd1));

  always_comb begin
    p_fail  = ST_OK;
    p_emit  = 1'b0;
    p_inc   = 1'b0;
    p_kind  = RK_NAME_START;
    p_entry = entry_r;
    p_fp    = fp_r;
    p_sr    = sr_r;
    case (entry_r)
      EN_NAME_SEL: begin
        if (!q_item.sel_ok || ({3'b0, q_item.sel_off} >= size9)) begin
          p_fail = ST_CORRUPT;
        end else begin
          p_fp    = {3'b0, q_item.sel_off};
          p_entry = EN_NAME_LEN;
        end
      end
      EN_NAME_LEN: begin
        if (fp_hit) begin
          if (str_over) begin
            p_fail = ST_CORRUPT;
          end else begin
            p_emit  = 1'b1;
            p_kind  = RK_NAME_START;
            p_sr    = b;
            p_entry = (b == 8'd0) ? EN_IDLE : EN_NAME_CHR;
          end
        end
      end
      EN_NAME_CHR: begin
        if (!q_item.printable) begin
          p_fail = ST_CORRUPT;
        end else begin
          p_emit = 1'b1;
          p_kind = RK_NAME_BYTE;
          p_sr   = sr_r - 8'd1;
          if (p_sr == 8'd0) p_entry = EN_IDLE;
        end
      end
      EN_EXP_TYPE: begin
        if (fp_hit) begin
          if (!q_item.skip_ok) begin
            p_fail = ST_CORRUPT;
          end else begin
            p_fp = fp_r + (q_item.skip8 ? 9'd6 : 9'd5);
            if (p_fp >= size9) p_fail = ST_CORRUPT;
            else p_entry = EN_EXP_LEN;
          end
        end
      end
      EN_EXP_LEN: begin
        if (fp_hit) begin
          if (limit_hit) begin
            p_fail = ST_EXPORTS;
          end else if (str_over) begin
            p_fail = ST_CORRUPT;
          end else begin
            p_inc  = 1'b1;
            p_emit = 1'b1;
            p_kind = RK_SYM_START;
            p_sr   = b;
            if (b != 8'd0) p_entry = EN_EXP_CHR;
          end
        end
      end
      EN_EXP_CHR: begin
        p_emit = 1'b1;
        p_kind = RK_SYM_BYTE;
        p_sr   = sr_r - 8'd1;
      end
      default: ;
    endcase
    // next entry starts right after a finished symbol
    if ((entry_r == EN_EXP_LEN && p_inc && b == 8'd0) ||
        (entry_r == EN_EXP_CHR && p_sr == 8'd0)) begin
      if ((posn9 + 9'd1) < size9) begin
        if ((posn9 + 9'd2) >= size9) begin
          p_fail = ST_CORRUPT;
        end else begin
          p_fp    = posn9 + 9'd2;
          p_entry = EN_EXP_TYPE;
        end
      end else begin
        p_entry = EN_IDLE;
      end
    end
    if (p_fail != ST_OK) p_entry = EN_IDLE;
  end

  // length byte: set up the first field of the payload
  always_comb begin
    l_short = (b < 8'd2);
    l_fail  = 1'b0;
    l_entry = EN_IDLE;
    if (is_name_r) begin
      if (size_len == 8'd0) l_fail = 1'b1;
      else l_entry = EN_NAME_SEL;
    end else if (is_exp_r) begin
      if (size_len == 8'd2) l_fail = 1'b1;
      else if (size_len > 8'd2) l_entry = EN_EXP_TYPE;
    end
  end

  always_comb begin
    verdict  = 1'b0;
    rerr_cur = rerr_r;
    if (phase_r == PH_LEN) begin
      verdict  = l_short || (size_len == 8'd0);
      rerr_cur = l_fail ? ST_CORRUPT : ST_OK;
    end else if (phase_r == PH_PAYLOAD) begin
      verdict  = (posn9 == size9);
      if (rerr_r == ST_OK) rerr_cur = p_fail;
    end
    if ((phase_r == PH_LEN && l_short) || sum_add != SUM_OK) v_status = ST_CORRUPT;
    else v_status = rerr_cur;
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    entry_nxt   = entry_r;
    is_name_nxt = is_name_r;
    is_exp_nxt  = is_exp_r;
    size_nxt    = size_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    fp_nxt      = fp_r;
    sr_nxt      = sr_r;
    rerr_nxt    = rerr_r;
    ferr_nxt    = ferr_r;
    exp_nxt     = exp_r;
    if (q_item.kind == IK_EOF) begin
      phase_nxt   = PH_TYPE;
      entry_nxt   = EN_IDLE;
      is_name_nxt = 1'b0;
      is_exp_nxt  = 1'b0;
      size_nxt    = '0;
      pos_nxt     = '0;
      sum_nxt     = '0;
      fp_nxt      = '0;
      sr_nxt      = '0;
      rerr_nxt    = ST_OK;
      ferr_nxt    = ST_OK;
      exp_nxt     = '0;
    end else begin
      case (phase_r)
        PH_TYPE: begin
          is_name_nxt = q_item.name_type;
          is_exp_nxt  = q_item.export_type;
          sum_nxt     = b;
          rerr_nxt    = ST_OK;
          entry_nxt   = EN_IDLE;
          phase_nxt   = PH_LEN;
        end
        PH_LEN: begin
          sum_nxt = sum_add;
          if (!l_short) begin
            size_nxt  = size_len;
            pos_nxt   = '0;
            entry_nxt = l_entry;
            rerr_nxt  = rerr_cur;
            if (l_entry == EN_EXP_TYPE) fp_nxt = 9'd2;
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt   = sum_add;
          entry_nxt = p_entry;
          fp_nxt    = p_fp;
          sr_nxt    = p_sr;
          rerr_nxt  = rerr_cur;
          pos_nxt   = pos_r + 8'd1;
          if (p_inc) exp_nxt = exp_r + 8'd1;
        end
        default: ;
      endcase
      if (verdict) begin
        entry_nxt = EN_IDLE;
        rerr_nxt  = v_status;
        if (v_status != ST_OK) begin
          ferr_nxt  = v_status;
          phase_nxt = PH_HALT;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
    end
  end

  // result of this item; a start or character is still sent when the entry
  // that follows it fails
  always_comb begin
    ev_valid        = 1'b0;
    ev              = '0;
    ev.export_count = exp_nxt;
    if (q_item.kind == IK_EOF) begin
      ev_valid        = 1'b1;
      ev.result_kind  = RK_FILE;
      ev.export_count = exp_r;
      if (phase_r == PH_HALT) ev.status = ferr_r;
      else if (phase_r == PH_PAYLOAD || exp_r == 8'd0) ev.status = ST_CORRUPT;
      else ev.status = ST_OK;
    end else if (verdict) begin
      ev_valid       = 1'b1;
      ev.result_kind = RK_REC;
      ev.status      = v_status;
    end else if (phase_r == PH_PAYLOAD && p_emit) begin
      ev_valid       = 1'b1;
      ev.result_kind = p_kind;
      ev.byte_value  = b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RST;
      phase_r  <= PH_TYPE;
      entry_r  <= EN_IDLE;
      is_name_r <= 1'b0;
      is_exp_r <= 1'b0;
      size_r   <= '0;
      pos_r    <= '0;
      sum_r    <= '0;
      fp_r     <= '0;
      sr_r     <= '0;
      rerr_r   <= ST_OK;
      ferr_r   <= ST_OK;
      exp_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_valid) limit_r <= cfg_data;
      if (take) begin
        phase_r   <= phase_nxt;
        entry_r   <= entry_nxt;
        is_name_r <= is_name_nxt;
        is_exp_r  <= is_exp_nxt;
        size_r    <= size_nxt;
        pos_r     <= pos_nxt;
        sum_r     <= sum_nxt;
        fp_r      <= fp_nxt;
        sr_r      <= sr_nxt;
        rerr_r    <= rerr_nxt;
        ferr_r    <= ferr_nxt;
        exp_r     <= exp_nxt;
        ov_r      <= ev_valid;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= ev;
  end

  assign out_valid = ov_r;
  assign out_res   = res_r;

endmodule

// ===== hw/rtl/object_record_parser.sv =====
// object_record_parser: top level of the object file record checker.
// Depends on orp_pkg, orp_front and orp_back.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in      | in  | in_tvalid/in_tready  | tdata: data_byte; tuser: kind
//  out     | out | out_tvalid/out_tready| tdata: byte_value,status,export_count
//          |     |                      | tuser: result_kind
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_data: export_limit
//
// One byte per cycle sustained while out is not stalled. An accepted byte
// lands in a 4-entry queue and is parsed once it reaches the head; its result
// (if any) is registered and shown on out. The parser steps one queued
// item per cycle whenever the result register is empty or being drained, so
// a stalled output backs up into the queue and then into in_tready.
// Synchronous active-low reset; export_limit resets to 200. cfg_ready is
// always high.
module object_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] kind: 0 byte, 1 end of file
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] byte_value, [9:8] status,
                                  // [17:10] export_count, [23:18] zero
  output logic [2:0]  out_tuser,  // [2:0] result_kind
  // export_limit register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import orp_pkg::*;

  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  orp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  orp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign cfg_ready = 1'b1;
  assign out_tuser = res.result_kind;
  assign out_tdata = {6'b0, res.export_count, res.status, res.byte_value};

  // result kinds stay within the defined set
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= RK_FILE))
    else $error("result kind out of range");

  // starts and characters carry no status
  a_str_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == RK_NAME_START || out_tuser == RK_NAME_BYTE ||
                   out_tuser == RK_SYM_START || out_tuser == RK_SYM_BYTE)
    |-> (res.status == ST_OK))
    else $error("status set on a string result");

  // verdicts carry a zero byte value and a defined status
  a_verdict_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == RK_REC || out_tuser == RK_FILE)
    |-> (res.byte_value == 8'd0) && (res.status != 2'd3))
    else $error("bad verdict payload");

  // a result after reset only follows an accepted queue item
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(q_pop))
    else $error("result without a parsed item");

endmodule

// ===== tb/sv/orp_result_check.sv =====
// orp_result_check: passive watcher of the object record parser's ports.
// Runs its own model of the parser on every input transfer and compares
// each result transfer with it. Depends on orp_pkg.
module orp_result_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic [0:0]  in_tuser,     // [0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,    // [7:0] byte_value, [9:8] status,
                                    // [17:10] export_count, [23:18] zero
  input  logic [2:0]  out_tuser,    // [2:0] result_kind
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,     // [7:0] export_limit
  output int          error_count,
  output int          results_open
);
  timeunit 1ns;
  timeprecision 1ps;
  import orp_pkg::*;

  // model state
  logic [7:0] lim;
  phase_t     rphase;
  logic [7:0] rtype;
  logic [7:0] psize;
  logic [7:0] ppos;
  logic [7:0] rsum;
  logic [8:0] fpos;
  logic [7:0] sleft;
  entry_t     ent;
  logic [1:0] rerr;
  logic [1:0] ferr;
  logic [7:0] nexp;

  // result raised by the current byte
  logic       ev_hit;
  logic [2:0] ev_kind;
  logic [7:0] ev_val;

  result_t    results_due[$];

  initial begin
    error_count  = 0;
    results_open = 0;
  end

  function automatic void clear_file();
    rphase = PH_TYPE;
    rtype  = '0;
    psize  = '0;
    ppos   = '0;
    rsum   = '0;
    fpos   = '0;
    sleft  = '0;
    ent    = EN_IDLE;
    rerr   = ST_OK;
    ferr   = ST_OK;
    nexp   = '0;
  endfunction

  // first error of a record sticks; parsing of the record stops
  function automatic void abort_record(logic [1:0] code);
    if (rerr == ST_OK) rerr = code;
    ent = EN_IDLE;
  endfunction

  function automatic void raise(logic [2:0] kind, logic [7:0] val);
    ev_hit  = 1'b1;
    ev_kind = kind;
    ev_val  = val;
  endfunction

  // next export entry at offset i, while the entry loop still runs
  function automatic void start_entry(int i);
    int sz;
    sz = int'(psize);
    if (i + 1 < sz) begin
      if (i + 2 >= sz) begin
        abort_record(ST_CORRUPT);
      end else begin
        fpos = 9'(i + 2);
        ent  = EN_EXP_TYPE;
      end
    end else begin
      ent = EN_IDLE;
    end
  endfunction

  function automatic void parse_payload(logic [7:0] b, int pos);
    int sz;
    int off;
    sz = int'(psize);
    case (ent)
      EN_NAME_SEL: begin
        if (b == SEL_C0 || b == SEL_B0) off = int'(OFF_1C);
        else if (b == SEL_A0) off = int'(OFF_20);
        else if (b == SEL_20) off = int'(OFF_24);
        else begin
          abort_record(ST_CORRUPT);
          return;
        end
        if (off >= sz) begin
          abort_record(ST_CORRUPT);
          return;
        end
        fpos = 9'(off);
        ent  = EN_NAME_LEN;
      end
      EN_NAME_LEN: begin
        if (pos != int'(fpos)) return;
        if (pos + int'(b) >= sz) begin
          abort_record(ST_CORRUPT);
          return;
        end
        raise(RK_NAME_START, b);
        sleft = b;
        ent   = (b == 8'd0) ? EN_IDLE : EN_NAME_CHR;
      end
      EN_NAME_CHR: begin
        if (b < CHR_LO || b > CHR_HI) begin
          abort_record(ST_CORRUPT);
          return;
        end
        raise(RK_NAME_BYTE, b);
        sleft = sleft - 8'd1;
        if (sleft == 8'd0) ent = EN_IDLE;
      end
      EN_EXP_TYPE: begin
        if (pos != int'(fpos)) return;
        if (b == ETYPE_00 || b == ETYPE_20) fpos = fpos + 9'd5;
        else if (b == ETYPE_40) fpos = fpos + 9'd6;
        else begin
          abort_record(ST_CORRUPT);
          return;
        end
        if (int'(fpos) >= sz) begin
          abort_record(ST_CORRUPT);
          return;
        end
        ent = EN_EXP_LEN;
      end
      EN_EXP_LEN: begin
        if (pos != int'(fpos)) return;
        // limit of zero wraps to 255 here
        if (nexp == 8'(lim - 8'd1)) begin
          abort_record(ST_EXPORTS);
          return;
        end
        if (pos + int'(b) >= sz) begin
          abort_record(ST_CORRUPT);
          return;
        end
        nexp = nexp + 8'd1;
        raise(RK_SYM_START, b);
        sleft = b;
        if (b == 8'd0) start_entry(pos + 1);
        else ent = EN_EXP_CHR;
      end
      EN_EXP_CHR: begin
        raise(RK_SYM_BYTE, b);
        sleft = sleft - 8'd1;
        if (sleft == 8'd0) start_entry(pos + 1);
      end
      default: ;
    endcase
  endfunction

  // forced == ST_OK: verdict from checksum and the sticky record error
  function automatic void close_record(logic [1:0] forced);
    logic [1:0] st;
    if (forced != ST_OK) st = forced;
    else if (rsum != SUM_OK) st = ST_CORRUPT;
    else st = rerr;
    raise(RK_REC, 8'd0);
    ent = EN_IDLE;
    if (st != ST_OK) begin
      ferr   = st;
      rphase = PH_HALT;
    end else begin
      rphase = PH_TYPE;
    end
    rerr = st;
  endfunction

  function automatic void parse_item(logic kind, logic [7:0] b, output logic hit,
                                     output result_t r);
    logic [1:0] st;
    ev_hit  = 1'b0;
    ev_kind = RK_NAME_START;
    ev_val  = '0;
    st      = ST_OK;
    if (kind == IK_EOF) begin
      if (rphase == PH_HALT) st = ferr;
      else if (rphase == PH_PAYLOAD) st = ST_CORRUPT;
      else if (nexp == 8'd0) st = ST_CORRUPT;
      r   = '{RK_FILE, 8'h00, st, nexp};
      hit = 1'b1;
      clear_file();
      return;
    end
    case (rphase)
      PH_TYPE: begin
        rtype  = b;
        rsum   = b;
        rerr   = ST_OK;
        ent    = EN_IDLE;
        rphase = PH_LEN;
      end
      PH_LEN: begin
        rsum = rsum + b;
        if (b < 8'd2) begin
          close_record(ST_CORRUPT);
        end else begin
          psize = b - 8'd2;
          ppos  = '0;
          ent   = EN_IDLE;
          if (rtype == TYPE_NAME_A || rtype == TYPE_NAME_B) begin
            if (psize == 8'd0) abort_record(ST_CORRUPT);
            else ent = EN_NAME_SEL;
          end else if (rtype == TYPE_EXP_A || rtype == TYPE_EXP_B) begin
            start_entry(0);
          end
          if (psize == 8'd0) close_record(ST_OK);
          else rphase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        rsum = rsum + b;
        parse_payload(b, int'(ppos));
        ppos = ppos + 8'd1;
        if (ppos == psize) close_record(ST_OK);
      end
      default: ;
    endcase
    hit = ev_hit;
    if (ev_kind == RK_REC) st = rerr;
    r = '{ev_kind, ev_val, st, nexp};
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t next_res;
    logic    hit;
    if (!rst_n) begin
      lim = LIMIT_RST;
      clear_file();
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) lim = cfg_data;
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $error("result_kind: no result awaited, got kind %0d data %0h",
                 out_tuser, out_tdata);
          error_count++;
        end else begin
          want = results_due.pop_front();
          check_field("result_kind", 8'(want.result_kind), 8'(out_tuser));
          check_field("byte_value", want.byte_value, out_tdata[7:0]);
          check_field("status", 8'(want.status), 8'(out_tdata[9:8]));
          check_field("export_count", want.export_count, out_tdata[17:10]);
          check_field("tdata_pad", 8'd0, 8'(out_tdata[23:18]));
        end
      end
      if (in_tvalid && in_tready) begin
        parse_item(in_tuser[0], in_tdata, hit, next_res);
        if (hit) results_due.push_back(next_res);
      end
    end
    results_open = results_due.size();
  end

endmodule

// ===== tb/sv/tb_object_record_parser.sv =====
// tb_object_record_parser: stimulus and verdict for the object record parser.
// Depends on orp_pkg, object_record_parser and orp_result_check.
module tb_object_record_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import orp_pkg::*;

  localparam int LIMIT_CYCLES = 200_000;
  localparam int DRAIN_CYCLES = 12;    // queue plus result register, with margin
  localparam int PHASE_BYTES  = 30;    // a phase ends with the file that crosses this
  localparam int N_PHASES     = 7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;    // [7:0] data_byte
  logic [0:0]  in_tuser   = '0;    // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [7:0] byte_value, [9:8] status,
                                   // [17:10] export_count, [23:18] zero
  logic [2:0]  out_tuser;          // [2:0] result_kind
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;    // [7:0] export_limit

  int          error_count;
  int          results_open;
  int          cycle_count = 0;
  int          bytes_sent  = 0;

  // percent chance per cycle of a sender gap / a receiver stall
  int          send_idle = 0;
  int          rx_stall  = 0;

  // record under construction: body is everything between length and checksum
  logic [7:0]  body_q[$];
  logic [7:0]  rec_q[$];

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // receiver side: random back-pressure at the current stall rate
  always @(posedge clk) out_tready <= ($urandom_range(99) >= rx_stall);

  object_record_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  orp_result_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .results_open (results_open)
  );

  // One input transfer. A gap, if drawn, drops tvalid first; otherwise tvalid
  // stays high from the previous transfer and only the data changes.
  task automatic send_byte(logic kind, logic [7:0] b);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_record();
    foreach (rec_q[i]) send_byte(IK_BYTE, rec_q[i]);
  endtask

  // sampled on the falling edge so the checker's count has settled
  task automatic wait_drained();
    @(negedge clk);
    while (results_open != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // type, length, body, then the checksum that makes the record sum to 0xFF
  function automatic void seal(logic [7:0] t);
    logic [7:0] sum;
    logic [7:0] len;
    len = 8'(body_q.size() + 3);
    sum = t + len;
    rec_q.delete();
    rec_q.push_back(t);
    rec_q.push_back(len);
    foreach (body_q[i]) begin
      rec_q.push_back(body_q[i]);
      sum = sum + body_q[i];
    end
    rec_q.push_back(SUM_OK - sum);
  endfunction

  // 1..3 well-formed entries: two free bytes, entry type, pad, length, symbol
  function automatic void build_export_body();
    int         n_ent;
    int         k;
    logic [7:0] et;
    n_ent = $urandom_range(1, 3);
    k = 0;
    for (int e = 0; e < n_ent; e++) begin
      body_q.push_back(8'($urandom));
      body_q.push_back(8'($urandom));
      case ($urandom_range(2))
        0:       et = ETYPE_00;
        1:       et = ETYPE_20;
        default: et = ETYPE_40;
      endcase
      body_q.push_back(et);
      repeat ((et == ETYPE_40) ? 5 : 4) body_q.push_back(8'($urandom));
      k = $urandom_range(0, 5);
      body_q.push_back(8'(k));
      repeat (k) body_q.push_back(8'($urandom));
    end
    // checksum doubles as the last symbol character
    if (k > 0 && $urandom_range(3) == 0) void'(body_q.pop_back());
  endfunction

  // selector, filler up to its offset, name length, mostly printable name
  function automatic void build_name_body();
    logic [7:0] sel;
    int         off;
    int         k;
    int         extra;
    case ($urandom_range(4))
      0: begin
        sel = SEL_C0;
        off = int'(OFF_1C);
      end
      1: begin
        sel = SEL_B0;
        off = int'(OFF_1C);
      end
      2: begin
        sel = SEL_A0;
        off = int'(OFF_20);
      end
      3: begin
        sel = SEL_20;
        off = int'(OFF_24);
      end
      default: begin
        sel = 8'($urandom);
        off = int'(OFF_1C);
      end
    endcase
    body_q.push_back(sel);
    repeat (off - 1) body_q.push_back(8'($urandom));
    k = $urandom_range(0, 6);
    body_q.push_back(8'(k));
    repeat (k) begin
      if ($urandom_range(9) == 0) body_q.push_back(8'($urandom));
      else body_q.push_back(8'($urandom_range(CHR_HI, CHR_LO)));
    end
    extra = $urandom_range(0, 2);
    // checksum as last name character: verdict wins, char still checked
    if (k > 0 && extra == 0 && $urandom_range(3) == 0) void'(body_q.pop_back());
    else repeat (extra) body_q.push_back(8'($urandom));
  endfunction

  // Fills rec_q with one record. About one in five is damaged; cut means the
  // stream ends inside the record.
  task automatic build_record(output bit broken, output bit cut);
    int         pick;
    int         keep;
    int         idx;
    logic [7:0] rec_type;
    broken = 1'b0;
    cut    = 1'b0;
    body_q.delete();
    pick = $urandom_range(99);
    if (pick < 45) begin
      rec_type = $urandom_range(1) ? TYPE_EXP_A : TYPE_EXP_B;
      build_export_body();
    end else if (pick < 75) begin
      rec_type = $urandom_range(1) ? TYPE_NAME_A : TYPE_NAME_B;
      build_name_body();
    end else begin
      rec_type = 8'($urandom);
      if (rec_type == TYPE_NAME_A || rec_type == TYPE_NAME_B ||
          rec_type == TYPE_EXP_A || rec_type == TYPE_EXP_B) rec_type = 8'h00;
      repeat ($urandom_range(0, 6)) body_q.push_back(8'($urandom));
    end
    if ($urandom_range(99) >= 20) begin
      seal(rec_type);
      return;
    end
    broken = 1'b1;
    case ($urandom_range(5))
      0: begin
        // structure damaged, checksum still right
        if (body_q.size() > 0) body_q[$urandom_range(body_q.size() - 1)] = 8'($urandom);
        seal(rec_type);
      end
      1: begin
        // shortened record: fields now reach past the checksum
        if (body_q.size() > 1) begin
          keep = $urandom_range(1, body_q.size() - 1);
          while (body_q.size() > keep) void'(body_q.pop_back());
        end
        seal(rec_type);
      end
      2: begin
        seal(rec_type);
        idx = $urandom_range(rec_q.size() - 1);
        rec_q[idx] = rec_q[idx] ^ 8'(1 << $urandom_range(7));
      end
      3: rec_q = '{rec_type, 8'($urandom_range(1))};
      4: rec_q = '{rec_type, 8'd2};
      default: begin
        seal(rec_type);
        keep = $urandom_range(2, rec_q.size() - 1);
        while (rec_q.size() > keep) void'(rec_q.pop_back());
        cut = 1'b1;
      end
    endcase
  endtask

  // One file: mostly a chain of records, sometimes raw noise, then end of file.
  task automatic send_file();
    int nrec;
    bit broken;
    bit cut;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 20)) send_byte(IK_BYTE, 8'($urandom));
    end else begin
      nrec = $urandom_range(0, 4);
      for (int r = 0; r < nrec; r++) begin
        build_record(broken, cut);
        send_record();
        // after a damaged record the rest of the file is ignored anyway
        if (cut || (broken && $urandom_range(99) < 70)) break;
      end
      if ($urandom_range(99) < 5) send_byte(IK_BYTE, 8'($urandom));
    end
    send_byte(IK_EOF, 8'($urandom));
  endtask

  // watchdog
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0] limits [N_PHASES];
    limits = '{8'd255, 8'd1, 8'd2, 8'd0, 8'd3, LIMIT_RST, 8'd0};
    limits[N_PHASES - 1] = 8'($urandom_range(1, 255));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty file, short lengths, halt, lone type byte
    send_byte(IK_EOF, 8'h00);          // no export accepted
    send_byte(IK_BYTE, TYPE_EXP_A);    // length below two
    send_byte(IK_BYTE, 8'h01);
    send_byte(IK_BYTE, 8'h55);         // file halted: ignored
    send_byte(IK_EOF, 8'hFF);
    send_byte(IK_BYTE, 8'hFD);         // length two, sums to 0xFF
    send_byte(IK_BYTE, 8'h02);
    send_byte(IK_BYTE, TYPE_NAME_A);   // name record with no room for a selector
    send_byte(IK_BYTE, 8'h02);
    send_byte(IK_EOF, 8'h00);
    body_q = '{8'h00, 8'hFF, ETYPE_40, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55,
               8'h01, 8'h7F};
    seal(TYPE_EXP_B);
    send_record();
    send_byte(IK_BYTE, TYPE_EXP_A);    // lone type byte before end of file
    send_byte(IK_EOF, 8'h00);

    // random phases; each sets its own limit and one of four idle patterns
    for (int p = 0; p < N_PHASES; p++) begin
      in_tvalid <= 1'b0;
      wait_drained();
      write_limit(limits[p]);
      case (p % 4)
        0: begin
          send_idle = 0;
          rx_stall  = 0;
        end
        1: begin
          send_idle = 78;
          rx_stall  = 0;
        end
        2: begin
          send_idle = 0;
          rx_stall  = 78;
        end
        default: begin
          send_idle = 10;
          rx_stall  = 10;
        end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_file();
    end

    in_tvalid <= 1'b0;
    wait_drained();
    if (results_open != 0) $error("%0d results never arrived", results_open);
    if (error_count == 0 && results_open == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
